@@ hw/rtl/hwad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Holt-Winters anomaly detector package
// Shared constants, handshake structs and fixed-point helpers.
// ----------------------------------------------------------------------------
package hwad_pkg;

  localparam int SEASON_LEN = 32;
  localparam int POS_W      = $clog2(SEASON_LEN);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BETA   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAMMA  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH = 2'd3;

  localparam logic [15:0] ALPHA_RST  = 16'd13107;
  localparam logic [15:0] BETA_RST   = 16'd6554;
  localparam logic [15:0] GAMMA_RST  = 16'd6554;
  localparam logic [15:0] THRESH_RST = 16'd768;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic [16:0]        ONE_G17 = 17'h10000;
  localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SAT_HI  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO  = 64'shFFFF_FFFF_8000_0000;

  // Divider: 48-bit magnitude dividend, 32-bit magnitude divisor.
  localparam int DIV_W      = 48;
  localparam int DIVS_W     = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  // Multiplier: 64-bit by 32-bit unsigned, shift-add.
  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = $clog2(MUL_B_W);

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_HI) return Q32_MAX;
    if (v < SAT_LO) return Q32_MIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    if (v[31]) return ~v + 32'd1;
    return v;
  endfunction

  // Signs and saturates a quotient magnitude; a zero divisor saturates, or gives zero for a zero numerator.
  function automatic logic signed [31:0] qfin(input logic num_neg, input logic num_zero,
                                              input logic den_zero, input logic den_neg,
                                              input logic [DIV_W-1:0] qmag);
    logic signed [63:0] mag64;
    mag64 = $signed({16'd0, qmag});
    if (den_zero) begin
      if (num_zero) return 32'sd0;
      if (num_neg) return Q32_MIN;
      return Q32_MAX;
    end
    if (num_neg ^ den_neg) return sat32(-mag64);
    return sat32(mag64);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hwad_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hwad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hw/rtl/hwad_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hwad_div
  import hwad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVS_W:0]      shifted;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIVS_W'(shifted - {1'b0, dvs_r}) : shifted[DIVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

@@ hw/rtl/hwad_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Unsigned wide product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hwad_mul
  import hwad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_P_W-1:0]   prod_r;
  logic [MUL_A_W:0]     upper;

  // The low half of prod_r holds the remaining multiplier bits.
  assign upper = prod_r[0] ? ({1'b0, prod_r[MUL_P_W-1:MUL_B_W]} + {1'b0, a_r})
                           : {1'b0, prod_r[MUL_P_W-1:MUL_B_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_B_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r    <= req.a;
      prod_r <= {{MUL_A_W{1'b0}}, req.b};
    end else if (busy_r) begin
      prod_r <= {upper, prod_r[MUL_B_W-1:1]};
    end
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.product = prod_r;

endmodule
`default_nettype wire

@@ hw/rtl/holt_winters_anomaly_detector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Holt-Winters anomaly detector
// Multiplicative seasonal forecaster with a Welford z-score test on the residual.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      sink       tuser: cmd; tdata: sample_value
//  out_     source     tdata: anomaly_flag, forecast_value
//  cfg_     sink       register index and 16-bit value, write only
//
// A restart request goes straight to the result step. A sample request is paced by
// the shared bit-serial divider (48 steps, three uses) and shift-add multiplier
// (32 steps, up to four uses, three of them only when the z-score test runs).
// Season factors live in a RAM with a valid bit per slot, so reset and restart
// need no clearing pass. A result waiting on out_tready holds only the final
// step; the next request is taken once it is placed.
// ----------------------------------------------------------------------------
module holt_winters_anomaly_detector_unit
  import hwad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample_value
  input  logic                   in_tuser,   // [0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] anomaly_flag, [32:1] forecast_value
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_FC, S_RES, S_MDIV, S_MDIVW, S_D2, S_M2W, S_Q1W,
    S_BMUL1, S_BMUL2, S_BFIN, S_Q2W, S_A1W, S_A2W, S_A3W, S_FIN
  } state_t;

  typedef enum logic [1:0] {B_LEVEL, B_TREND, B_SEASON} bsel_t;

  state_t state_r;
  bsel_t  bsel_r;

  logic [15:0] alpha_r, beta_r, gamma_r, thresh_r;

  logic signed [31:0]     level_r, trend_r, x_r, season_r, sum_r, fc_r;
  logic [POS_W-1:0]       pos_r;
  logic [SEASON_LEN-1:0]  seas_valid_r;
  logic [31:0]            avg_r, count_r, r_r, dmag_r;
  logic                   dneg_r;
  logic [63:0]            m2_r;
  logic [MUL_P_W-1:0]     lhs_r;
  logic                   den_neg_r, den_zero_r;
  logic                   flag_r;
  logic [15:0]            bgain_r;
  logic signed [33:0]     bfresh_r, bold_r;
  logic signed [51:0]     acc_r;

  logic                   out_valid_r, out_flag_r;
  logic signed [31:0]     out_fc_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     div_start_r, mul_start_r;
  logic [DIV_W-1:0]   div_dvd_r;
  logic [DIVS_W-1:0]  div_dvs_r;
  logic [MUL_A_W-1:0] mul_a_r;
  logic [MUL_B_W-1:0] mul_b_r;

  logic               in_acc;
  logic [31:0]        ram_rdata;
  logic               ram_we;
  logic signed [63:0] fc_prod;
  logic signed [32:0] diff;
  logic [31:0]        x_mag;
  logic               x_zero;
  logic [31:0]        mag2;
  logic [64:0]        m2_sum;
  logic signed [31:0] q_val;
  logic signed [51:0] gain_ext, ginv_ext, fresh_ext, old_ext;
  logic signed [51:0] acc_sh;
  logic signed [31:0] blend_res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign fc_prod   = sum_r * season_r;
  assign diff      = $signed({x_r[31], x_r}) - $signed({fc_r[31], fc_r});
  assign x_mag     = abs32(x_r);
  assign x_zero    = (x_r == 32'sd0);
  assign mag2      = (r_r < avg_r) ? (avg_r - r_r) : (r_r - avg_r);
  assign m2_sum    = {1'b0, m2_r} + {1'b0, mul_rsp.product[63:0]};
  assign q_val     = qfin(x_r[31], x_zero, den_zero_r, den_neg_r,
                          div_rsp.quotient);

  // Blend: gain * fresh + (1.0 - gain) * old, floored to Q16.16.
  assign gain_ext  = $signed({36'd0, bgain_r});
  assign ginv_ext  = $signed({35'd0, 17'(ONE_G17 - {1'b0, bgain_r})});
  assign fresh_ext = {{18{bfresh_r[33]}}, bfresh_r};
  assign old_ext   = {{18{bold_r[33]}}, bold_r};
  assign acc_sh    = acc_r >>> 16;
  assign blend_res = sat32({{12{acc_sh[51]}}, acc_sh});

  assign ram_we = (state_r == S_BFIN) && (bsel_r == B_SEASON);

  hwad_ram #(.WIDTH(32), .DEPTH(SEASON_LEN)) u_season_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pos_r),
    .wr_data (blend_res),
    .rd_en   (in_acc),
    .rd_addr (pos_r),
    .rd_data (ram_rdata)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;
  assign mul_req.start    = mul_start_r;
  assign mul_req.a        = mul_a_r;
  assign mul_req.b        = mul_b_r;

  hwad_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  hwad_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RST;
      beta_r   <= BETA_RST;
      gamma_r  <= GAMMA_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ALPHA:  alpha_r  <= cfg_wdata;
        REG_BETA:   beta_r   <= cfg_wdata;
        REG_GAMMA:  gamma_r  <= cfg_wdata;
        REG_THRESH: thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bsel_r       <= B_LEVEL;
      level_r      <= '0;
      trend_r      <= '0;
      pos_r        <= '0;
      seas_valid_r <= '0;
      avg_r        <= '0;
      m2_r         <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      div_start_r  <= 1'b0;
      mul_start_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      // In S_FIN the outgoing result is replaced in the same cycle.
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r <= in_tdata;
            if (in_tuser == CMD_RESTART) begin
              level_r      <= in_tdata;
              trend_r      <= '0;
              pos_r        <= '0;
              seas_valid_r <= '0;
              avg_r        <= '0;
              m2_r         <= '0;
              count_r      <= '0;
              flag_r       <= 1'b0;
              fc_r         <= '0;
              state_r      <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          season_r <= seas_valid_r[pos_r] ? ram_rdata : ONE_Q16;
          sum_r    <= sat32(64'(level_r) + 64'(trend_r));
          state_r  <= S_FC;
        end
        S_FC: begin
          fc_r    <= sat32(fc_prod >>> 16);
          state_r <= S_RES;
        end
        S_RES: begin
          r_r     <= diff[32] ? 32'(-diff) : diff[31:0];
          count_r <= (count_r == '1) ? count_r : count_r + 32'd1;
          state_r <= S_MDIV;
        end
        S_MDIV: begin
          dneg_r      <= r_r < avg_r;
          dmag_r      <= mag2;
          div_dvd_r   <= DIV_W'(mag2);
          div_dvs_r   <= count_r;
          div_start_r <= 1'b1;
          state_r     <= S_MDIVW;
        end
        S_MDIVW: begin
          if (div_rsp.done) begin
            avg_r   <= dneg_r ? avg_r - div_rsp.quotient[31:0]
                              : avg_r + div_rsp.quotient[31:0];
            state_r <= S_D2;
          end
        end
        S_D2: begin
          mul_a_r     <= MUL_A_W'(dmag_r);
          mul_b_r     <= mag2;
          mul_start_r <= 1'b1;
          state_r     <= S_M2W;
        end
        S_M2W: begin
          if (mul_rsp.done) begin
            m2_r        <= m2_sum[64] ? '1 : m2_sum[63:0];
            div_dvd_r   <= {x_mag, 16'd0};
            div_dvs_r   <= abs32(season_r);
            den_neg_r   <= season_r[31];
            den_zero_r  <= season_r == 32'sd0;
            div_start_r <= 1'b1;
            state_r     <= S_Q1W;
          end
        end
        S_Q1W: begin
          if (div_rsp.done) begin
            bgain_r  <= alpha_r;
            bfresh_r <= 34'(q_val);
            bold_r   <= 34'(level_r) + 34'(trend_r);
            bsel_r   <= B_LEVEL;
            state_r  <= S_BMUL1;
          end
        end
        S_BMUL1: begin
          acc_r   <= gain_ext * fresh_ext;
          state_r <= S_BMUL2;
        end
        S_BMUL2: begin
          acc_r   <= acc_r + ginv_ext * old_ext;
          state_r <= S_BFIN;
        end
        S_BFIN: begin
          case (bsel_r)
            B_LEVEL: begin
              // Trend blends the level step; level_r still holds the old level.
              level_r  <= blend_res;
              bfresh_r <= 34'(blend_res) - 34'(level_r);
              bold_r   <= 34'(trend_r);
              bgain_r  <= beta_r;
              bsel_r   <= B_TREND;
              state_r  <= S_BMUL1;
            end
            B_TREND: begin
              trend_r     <= blend_res;
              div_dvd_r   <= {x_mag, 16'd0};
              div_dvs_r   <= abs32(level_r);
              den_neg_r   <= level_r[31];
              den_zero_r  <= level_r == 32'sd0;
              div_start_r <= 1'b1;
              state_r     <= S_Q2W;
            end
            default: begin
              seas_valid_r[pos_r] <= 1'b1;
              pos_r <= (pos_r == POS_W'(SEASON_LEN - 1)) ? '0 : pos_r + 1'b1;
              if (count_r > 32'(SEASON_LEN) && m2_r != '0) begin
                mul_a_r     <= MUL_A_W'(r_r);
                mul_b_r     <= r_r;
                mul_start_r <= 1'b1;
                state_r     <= S_A1W;
              end else begin
                flag_r  <= 1'b0;
                state_r <= S_FIN;
              end
            end
          endcase
        end
        S_Q2W: begin
          if (div_rsp.done) begin
            bgain_r  <= gamma_r;
            bfresh_r <= 34'(q_val);
            bold_r   <= 34'(season_r);
            bsel_r   <= B_SEASON;
            state_r  <= S_BMUL1;
          end
        end
        S_A1W: begin
          if (mul_rsp.done) begin
            mul_a_r     <= mul_rsp.product[63:0];
            mul_b_r     <= count_r;
            mul_start_r <= 1'b1;
            state_r     <= S_A2W;
          end
        end
        S_A2W: begin
          if (mul_rsp.done) begin
            lhs_r       <= mul_rsp.product;
            mul_a_r     <= m2_r;
            mul_b_r     <= {16'd0, thresh_r} * {16'd0, thresh_r};
            mul_start_r <= 1'b1;
            state_r     <= S_A3W;
          end
        end
        S_A3W: begin
          if (mul_rsp.done) begin
            // residual^2 * count * 65536 against threshold^2 * M2.
            flag_r  <= {lhs_r, 16'd0} > {16'd0, mul_rsp.product};
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_flag_r  <= flag_r;
            out_fc_r    <= fc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fc_r, out_flag_r};

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!div_rsp.busy && !mul_rsp.busy))
    else $error("request taken while an arithmetic unit is busy");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_RESTART) |=>
      (state_r == S_FIN && !flag_r && fc_r == 32'sd0))
    else $error("restart did not produce a cleared result");

endmodule
`default_nettype wire

@@ verif/hwad_forecast_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holt-Winters detector result checker
// Watches the sample, result and register ports. It keeps its own forecaster
// state and compares every result with the oldest outstanding forecast.
// ----------------------------------------------------------------------------
module hwad_forecast_checker
  import hwad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_count,
  output int                     pending_count,
  output int                     anomaly_count
);

  typedef struct {
    logic        anomaly;
    logic [31:0] forecast;
  } forecast_t;

  forecast_t   forecast_q[$];

  bit [15:0]   alpha, beta, gamma, thresh;
  longint      level, trend, avg_res;
  longint      factor[SEASON_LEN];
  int unsigned slot;
  bit [63:0]   sq_sum;
  bit [31:0]   seen;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q16_div(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return clip32((num * 65536) / den);
  endfunction

  function automatic longint smooth(bit [15:0] g, longint fresh, longint old);
    longint gl;
    gl = longint'(g);
    return clip32((gl * fresh + (65536 - gl) * old) >>> 16);
  endfunction

  task automatic restart_model(longint v);
    level   = v;
    trend   = 0;
    for (int i = 0; i < SEASON_LEN; i++) factor[i] = 65536;
    slot    = 0;
    avg_res = 0;
    sq_sum  = '0;
    seen    = '0;
  endtask

  task automatic forecast_step(input logic cmd, input logic signed [31:0] x,
                               output forecast_t res);
    longint    xv, seas, fc, diff, delta, delta2, prev, q;
    bit [63:0] r, mag, mag2, prod;
    bit [127:0] lhs, rhs;
    xv = longint'(x);
    res.anomaly = 1'b0;
    res.forecast = '0;
    if (cmd == CMD_RESTART) begin
      restart_model(xv);
      return;
    end
    seas = factor[slot];
    fc = clip32((clip32(level + trend) * seas) >>> 16);
    diff = xv - fc;
    r = (diff < 0) ? -diff : diff;
    if (seen != 32'hFFFF_FFFF) seen++;
    delta = longint'(r) - avg_res;
    avg_res += delta / longint'(seen);
    delta2 = longint'(r) - avg_res;
    mag  = (delta < 0) ? -delta : delta;
    mag2 = (delta2 < 0) ? -delta2 : delta2;
    prod = mag * mag2;
    sq_sum = (sq_sum > (64'hFFFF_FFFF_FFFF_FFFF - prod)) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                        : sq_sum + prod;
    prev = level;
    q = q16_div(xv, seas);
    level = smooth(alpha, q, prev + trend);
    trend = smooth(beta, level - prev, trend);
    q = q16_div(xv, level);
    factor[slot] = smooth(gamma, q, seas);
    slot = (slot + 1) % SEASON_LEN;
    // Exact z test: residual^2 * count * 2^16 against threshold^2 * M2.
    if (seen > SEASON_LEN && sq_sum != 0) begin
      lhs = {64'd0, 64'(r * r)} * {64'd0, 16'd0, seen, 16'd0};
      rhs = {64'd0, 64'(thresh) * 64'(thresh)} * {64'd0, sq_sum};
      res.anomaly = (lhs > rhs);
    end
    res.forecast = fc[31:0];
  endtask

  initial begin
    alpha = ALPHA_RST;
    beta = BETA_RST;
    gamma = GAMMA_RST;
    thresh = THRESH_RST;
    restart_model(0);
    mismatch_count = 0;
    pending_count = 0;
    anomaly_count = 0;
  end

  always @(posedge clk) begin
    forecast_t exp_res;
    forecast_t got;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ALPHA:  alpha  = cfg_wdata;
          REG_BETA:   beta   = cfg_wdata;
          REG_GAMMA:  gamma  = cfg_wdata;
          REG_THRESH: thresh = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        forecast_step(in_tuser, in_tdata[31:0], exp_res);
        forecast_q.push_back(exp_res);
      end
      if (out_tvalid && out_tready) begin
        got.anomaly  = out_tdata[0];
        got.forecast = out_tdata[32:1];
        if (got.anomaly) anomaly_count++;
        if (forecast_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result with nothing outstanding: flag=%0b forecast=%h",
                     got.anomaly, got.forecast);
        end else begin
          exp_res = forecast_q.pop_front();
          if (got.anomaly !== exp_res.anomaly || got.forecast !== exp_res.forecast) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: flag exp %0b got %0b, forecast exp %h got %h",
                       exp_res.anomaly, got.anomaly, exp_res.forecast, got.forecast);
          end
        end
      end
      pending_count = forecast_q.size();
    end
  end

endmodule

@@ verif/tb_holt_winters_anomaly_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holt-Winters anomaly detector testbench
// Drives directed and seasonal random sample streams under several gain and
// threshold settings with random stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_holt_winters_anomaly_detector_unit;
  import hwad_pkg::*;

  localparam int NUM_ITEMS = 1850;
  localparam int IDLE_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] sample_value
  logic                   in_tuser;   // [0] cmd
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] anomaly_flag, [32:1] forecast_value
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int mismatch_count, pending_count, anomaly_count;
  int tx_idle_pct, rx_idle_pct;
  int sent, restarts, settings_used;
  int idle_cycles;

  always #1 clk = ~clk;

  holt_winters_anomaly_detector_unit i_dut (.*);

  hwad_forecast_checker i_checker (.*);

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [31:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (cmd == CMD_RESTART) restarts++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] a, b, g, t);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_ALPHA;  cfg_wdata <= a; @(posedge clk);
    cfg_addr <= REG_BETA;   cfg_wdata <= b; @(posedge clk);
    cfg_addr <= REG_GAMMA;  cfg_wdata <= g; @(posedge clk);
    cfg_addr <= REG_THRESH; cfg_wdata <= t; @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // A restart followed by a seasonal stream with noise and rare spikes.
  task automatic seasonal_run();
    longint base, amp, noise, v;
    int len, period;
    base = $urandom_range(1, 20) == 1 ? longint'($signed($urandom()))
                                      : longint'($urandom_range(0, 200 << 16)) - (100 << 16);
    amp = longint'($urandom_range(0, 20 << 16));
    noise = longint'($urandom_range(0, 1 << 16));
    period = $urandom_range(2, 40);
    len = $urandom_range(35, 90);
    send(CMD_RESTART, base[31:0]);
    for (int i = 0; i < len && sent < NUM_ITEMS; i++) begin
      v = base + ((i % period) < period / 2 ? amp : -amp)
          + longint'($urandom_range(0, 2 * noise)) - noise;
      if ($urandom_range(99) < 3) v += longint'($signed($urandom()));
      send(CMD_SAMPLE, clamp32(v));
    end
  endtask

  initial begin
    logic [15:0] r_a, r_b, r_g, r_t;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = CMD_SAMPLE;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = REG_ALPHA;
    cfg_wdata = '0;
    out_tready = 1'b0;
    idle_cycles = 0;
    tx_idle_pct = 22;
    rx_idle_pct = 55;
    sent = 0;
    restarts = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, restarts at the limits, zero level for divide by zero.
    send(CMD_SAMPLE, 32'h0001_0000);
    send(CMD_SAMPLE, 32'h7FFF_FFFF);
    send(CMD_SAMPLE, 32'h8000_0000);
    send(CMD_RESTART, 32'h7FFF_FFFF);
    send(CMD_SAMPLE, 32'h7FFF_FFFF);
    send(CMD_SAMPLE, 32'h8000_0000);
    send(CMD_RESTART, 32'h8000_0000);
    send(CMD_SAMPLE, 32'h8000_0000);
    send(CMD_SAMPLE, 32'hFFFF_FFFF);
    send(CMD_RESTART, 32'h0000_0000);
    send(CMD_SAMPLE, 32'h0000_0000);
    send(CMD_SAMPLE, 32'h0000_0000);
    write_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send(CMD_RESTART, 32'h0000_0000);
    send(CMD_SAMPLE, 32'h0003_0000);
    send(CMD_SAMPLE, 32'hFFFD_0000);
    send(CMD_SAMPLE, 32'h0000_0000);
    send(CMD_SAMPLE, 32'h0005_0000);
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_RESTART, 32'h0010_0000);
    send(CMD_SAMPLE, 32'h7FFF_FFFF);
    send(CMD_SAMPLE, 32'h8000_0000);
    write_regs(ALPHA_RST, BETA_RST, GAMMA_RST, THRESH_RST);
    // The sender holds off here until everything sent so far has come back.
    drain();

    while (sent < NUM_ITEMS) begin
      if (sent > NUM_ITEMS / 3 && tx_idle_pct == 22) begin
        tx_idle_pct = 55;
        rx_idle_pct = 22;
      end else if (sent > 2 * NUM_ITEMS / 3 && tx_idle_pct == 55) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: begin r_a = 16'h0000; r_b = 16'h0000; r_g = 16'h0000; r_t = 16'h0000; end
          1: begin r_a = 16'hFFFF; r_b = 16'hFFFF; r_g = 16'hFFFF; r_t = 16'hFFFF; end
          2: begin r_a = ALPHA_RST; r_b = BETA_RST; r_g = GAMMA_RST;
                   r_t = 16'($urandom_range(64, 1024)); end
          default: begin r_a = 16'($urandom()); r_b = 16'($urandom());
                         r_g = 16'($urandom()); r_t = 16'($urandom()); end
        endcase
        write_regs(r_a, r_b, r_g, r_t);
      end
      if ($urandom_range(9) < 8) begin
        seasonal_run();
      end else begin
        repeat ($urandom_range(3, 15))
          send($urandom_range(19) == 0 ? CMD_RESTART : CMD_SAMPLE, $urandom());
      end
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d requests (%0d restarts) under %0d register settings;",
             sent, restarts, settings_used);
    $display("%0d anomalies flagged, %0d mismatches.", anomaly_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
